FILE: design/pdt_pkg.sv
// Shared types and constants for the prescaled down-counter timer.
// No dependencies; compile first.
`default_nettype none

package pdt_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int READ_WIDTH  = 16;
	localparam int PS_WIDTH    = 12;
	localparam int ADDR_WIDTH  = 8;
	localparam int DATA_WIDTH  = 32;
	// internal read bus: wide enough for the counter and for the read port
	localparam int RD_WIDTH    = (COUNT_WIDTH > READ_WIDTH) ? COUNT_WIDTH : READ_WIDTH;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [ADDR_WIDTH-1:0] ADDR_LOAD  = 8'd0;
	localparam logic [ADDR_WIDTH-1:0] ADDR_VALUE = 8'd1;
	localparam logic [ADDR_WIDTH-1:0] ADDR_CTRL  = 8'd2;
	localparam logic [ADDR_WIDTH-1:0] ADDR_CLEAR = 8'd3;
	localparam logic [ADDR_WIDTH-1:0] ADDR_RSVD  = 8'd4;

	localparam int CTRL_EN_BIT  = 7;
	localparam int CTRL_PER_BIT = 6;
	localparam int CTRL_PS_LSB  = 2;

	typedef struct packed {
		cmd_t                  cmd;
		logic [ADDR_WIDTH-1:0] reg_addr;
		logic [DATA_WIDTH-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic [READ_WIDTH-1:0] read_value;
		logic                  access_status;
		logic                  irq_level;
	} rsp_t;

endpackage

`default_nettype wire

FILE: design/pdt_req_if.sv
// Request channel of the timer: tick, register read or register write.
// Depends on pdt_pkg.
`default_nettype none

interface pdt_req_if;
	import pdt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            cmd;
	logic [ADDR_WIDTH-1:0] reg_addr;
	logic [DATA_WIDTH-1:0] write_value;

	modport source (output valid, cmd, reg_addr, write_value, input ready);
	modport sink   (input valid, cmd, reg_addr, write_value, output ready);
endinterface

`default_nettype wire

FILE: design/pdt_rsp_if.sv
// Response channel of the timer: read data, access status, interrupt level.
// Depends on pdt_pkg.
`default_nettype none

interface pdt_rsp_if;
	import pdt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [READ_WIDTH-1:0] read_value;
	logic                  access_status;
	logic                  irq_level;

	modport source (output valid, read_value, access_status, irq_level, input ready);
	modport sink   (input valid, read_value, access_status, irq_level, output ready);
endinterface

`default_nettype wire

FILE: design/pdt_core.sv
// Timer state, prescaler and register decode. One transaction per step.
// Depends on pdt_pkg.
`default_nettype none

module pdt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  pdt_pkg::req_t item,
	output pdt_pkg::rsp_t result
);
	import pdt_pkg::*;

	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [COUNT_WIDTH-1:0] reload_q, reload_d;
	logic                   run_en_q, run_en_d;
	logic                   periodic_q, periodic_d;
	logic [1:0]             ps_sel_q, ps_sel_d;
	logic [PS_WIDTH-1:0]    ps_cnt_q, ps_cnt_d;
	logic                   irq_q, irq_d;

	logic [PS_WIDTH-1:0]    ps_mask;
	logic [PS_WIDTH-1:0]    ps_next;
	logic [COUNT_WIDTH-1:0] count_dec;
	logic [RD_WIDTH-1:0]    rd;
	logic                   status;

	// divide by 16^sel: low 4*sel bits of the prescaler must roll over
	assign ps_mask   = ~({PS_WIDTH{1'b1}} << {ps_sel_q, 2'b00});
	assign ps_next   = ps_cnt_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	always_comb begin
		count_d    = count_q;
		reload_d   = reload_q;
		run_en_d   = run_en_q;
		periodic_d = periodic_q;
		ps_sel_d   = ps_sel_q;
		ps_cnt_d   = ps_cnt_q;
		irq_d      = irq_q;
		rd         = '0;
		status     = 1'b0;

		case (item.cmd)
			CMD_TICK: begin
				if (run_en_q) begin
					if ((ps_next & ps_mask) == '0) begin
						ps_cnt_d = '0;
						if (count_dec == '0) begin
							if (periodic_q) begin
								count_d = reload_q;
								irq_d   = 1'b1;
							end else begin
								count_d = '1;
							end
						end else begin
							count_d = count_dec;
						end
					end else begin
						ps_cnt_d = ps_next;
					end
				end
			end
			CMD_READ: begin
				case (item.reg_addr)
					ADDR_LOAD:  rd = RD_WIDTH'(reload_q);
					ADDR_VALUE: rd = RD_WIDTH'(count_q);
					ADDR_CTRL:  rd = RD_WIDTH'({run_en_q, periodic_q, 2'b00, ps_sel_q, 2'b00});
					ADDR_CLEAR: rd = '0;
					ADDR_RSVD:  rd = '0;
					default:    status = 1'b1;
				endcase
			end
			CMD_WRITE: begin
				case (item.reg_addr)
					ADDR_LOAD: begin
						reload_d = item.write_value[COUNT_WIDTH-1:0];
						count_d  = item.write_value[COUNT_WIDTH-1:0];
					end
					ADDR_VALUE: ;
					ADDR_CTRL: begin
						ps_sel_d   = item.write_value[CTRL_PS_LSB +: 2];
						run_en_d   = item.write_value[CTRL_EN_BIT];
						periodic_d = item.write_value[CTRL_PER_BIT];
					end
					ADDR_CLEAR: irq_d = 1'b0;
					ADDR_RSVD:  ;
					default:    status = 1'b1;
				endcase
			end
			default: ;
		endcase
	end

	assign result.read_value    = rd[READ_WIDTH-1:0];
	assign result.access_status = status;
	assign result.irq_level     = irq_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reload_q   <= '0;
			run_en_q   <= 1'b0;
			periodic_q <= 1'b0;
			ps_sel_q   <= '0;
			ps_cnt_q   <= '0;
			irq_q      <= 1'b0;
		end else if (step) begin
			count_q    <= count_d;
			reload_q   <= reload_d;
			run_en_q   <= run_en_d;
			periodic_q <= periodic_d;
			ps_sel_q   <= ps_sel_d;
			ps_cnt_q   <= ps_cnt_d;
			irq_q      <= irq_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/prescaled_down_counter_timer_unit.sv
// Each result passes the input register, then the result register, after its
// request is accepted, and is held back only while rsp is stalled.
// Throughput: one transaction per cycle while rsp is not stalled; the timer update
// is a single decrement and compare in pdt_core between the two registers.
// Reset: arst_n clears the pipeline valids and all timer state (counter,
// load value, control fields, prescaler, interrupt) at once.
`default_nettype none

module prescaled_down_counter_timer_unit (
	input  logic        clk,
	input  logic        arst_n,
	pdt_req_if.sink     req,
	pdt_rsp_if.source   rsp
);
	import pdt_pkg::*;

	logic  s1_valid_q;
	req_t  item_s1;
	logic  s1_adv;
	logic  rsp_valid_q;
	rsp_t  rsp_q;
	rsp_t  result;
	req_t  req_item;

	assign req_item.cmd         = cmd_t'(req.cmd);
	assign req_item.reg_addr    = req.reg_addr;
	assign req_item.write_value = req.write_value;

	// stage 1 moves on whenever the result register is free or being emptied
	assign s1_adv    = s1_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.valid && req.ready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req_item;
		end
	end

	pdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_adv),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.read_value    = rsp_q.read_value;
	assign rsp.access_status = rsp_q.access_status;
	assign rsp.irq_level     = rsp_q.irq_level;

endmodule

`default_nettype wire

FILE: design/pdt_chk.sv
// Port-level checks for the timer unit, bound to the top level.
// Depends on pdt_pkg and prescaled_down_counter_timer_unit.
`default_nettype none

module pdt_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [pdt_pkg::READ_WIDTH-1:0] rsp_read_value,
	input logic                           rsp_access_status
);
	import pdt_pkg::*;

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	// backpressure on req only when the result register is full and stalled
	a_req_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("req stalled without rsp backpressure");

	// a transaction accepted into an empty pipe shows a result once it has passed both registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> ##1 rsp_valid)
		else $error("result missing after accepted transaction");

	// unmapped accesses return zero data
	a_unmapped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_access_status |-> rsp_read_value == '0)
		else $error("unmapped access returned nonzero data");

endmodule

bind prescaled_down_counter_timer_unit pdt_chk u_pdt_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_read_value    (rsp.read_value),
	.rsp_access_status (rsp.access_status)
);

`default_nettype wire

FILE: bench/prescaled_down_counter_timer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for prescaled_down_counter_timer_unit: ticks and register accesses
// go in, every response is predicted by an in-bench timer model and compared in order.
// Depends on pdt_pkg, pdt_req_if, pdt_rsp_if and the timer top level.

module prescaled_down_counter_timer_unit_tb;
	import pdt_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int MAX_GAP      = 7;
	localparam int REPORT_LIMIT = 10;
	localparam int ADDR_MAX     = (1 << ADDR_WIDTH) - 1;

	localparam logic [DATA_WIDTH-1:0] CTRL_ENABLE   = 32'h80;
	localparam logic [DATA_WIDTH-1:0] CTRL_PERIODIC = 32'h40;
	localparam logic [1:0] PS_DIV1    = 2'd0;
	localparam logic [1:0] PS_DIV16   = 2'd1;
	localparam logic [1:0] PS_DIV256  = 2'd2;
	localparam logic [1:0] PS_DIV4096 = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	pdt_req_if req_ch();
	pdt_rsp_if rsp_ch();

	prescaled_down_counter_timer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// timer state as the bench sees it
	logic [COUNT_WIDTH-1:0] tmr_count;
	logic [COUNT_WIDTH-1:0] tmr_reload;
	logic                   tmr_enable;
	logic                   tmr_periodic;
	logic [1:0]             tmr_prescale;
	logic [PS_WIDTH-1:0]    tmr_ps_count;
	logic                   tmr_irq;

	rsp_t pending_rsp[$];

	int  items_sent;
	int  rsp_checked;
	int  mismatches;
	int  irq_raises;
	int  cycle_count;
	bit  send_steady;
	bit  recv_steady;
	int  rsp_hold_cycles;

	function automatic rsp_t timer_response(cmd_t cmd, logic [ADDR_WIDTH-1:0] addr,
			logic [DATA_WIDTH-1:0] data);
		rsp_t           r;
		int unsigned    div_mask;
		logic [PS_WIDTH:0] ps_next;
		r = '0;
		case (cmd)
		CMD_TICK: begin
			if (tmr_enable) begin
				div_mask = (32'd1 << (tmr_prescale * 4)) - 1;
				ps_next  = tmr_ps_count + 1'b1;
				if ((ps_next & div_mask) == 0) begin
					tmr_ps_count = '0;
					tmr_count    = tmr_count - 1'b1;
					if (tmr_count == '0) begin
						if (tmr_periodic) begin
							tmr_count = tmr_reload;
							tmr_irq   = 1'b1;
							irq_raises++;
						end else begin
							tmr_count = '1;
						end
					end
				end else begin
					tmr_ps_count = ps_next[PS_WIDTH-1:0];
				end
			end
		end
		CMD_READ: begin
			case (addr)
			ADDR_LOAD:  r.read_value = tmr_reload;
			ADDR_VALUE: r.read_value = tmr_count;
			ADDR_CTRL: begin
				r.read_value[CTRL_EN_BIT]             = tmr_enable;
				r.read_value[CTRL_PER_BIT]            = tmr_periodic;
				r.read_value[CTRL_PS_LSB +: 2]        = tmr_prescale;
			end
			ADDR_CLEAR, ADDR_RSVD: r.read_value = '0;
			default: r.access_status = 1'b1;
			endcase
		end
		CMD_WRITE: begin
			case (addr)
			ADDR_LOAD: begin
				tmr_reload = data[COUNT_WIDTH-1:0];
				tmr_count  = data[COUNT_WIDTH-1:0];
			end
			ADDR_VALUE, ADDR_RSVD: begin
			end
			ADDR_CTRL: begin
				tmr_prescale = data[CTRL_PS_LSB +: 2];
				tmr_enable   = data[CTRL_EN_BIT];
				tmr_periodic = data[CTRL_PER_BIT];
			end
			ADDR_CLEAR: tmr_irq = 1'b0;
			default: r.access_status = 1'b1;
			endcase
		end
		default: begin
		end
		endcase
		r.irq_level = tmr_irq;
		return r;
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is accepted.
	task automatic send_item(cmd_t cmd, logic [ADDR_WIDTH-1:0] addr,
			logic [DATA_WIDTH-1:0] data);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.cmd         <= cmd;
		req_ch.reg_addr    <= addr;
		req_ch.write_value <= data;
		do @(posedge clk); while (!req_ch.ready);
		pending_rsp.push_back(timer_response(cmd, addr, data));
		items_sent++;
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_item(CMD_TICK, ADDR_WIDTH'($urandom_range(0, ADDR_MAX)), $urandom());
	endtask

	task automatic send_random_item();
		cmd_t                  cmd;
		logic [ADDR_WIDTH-1:0] addr;
		logic [DATA_WIDTH-1:0] data;
		int                    pick;
		pick = $urandom_range(0, 99);
		data = $urandom();
		addr = ADDR_WIDTH'($urandom_range(0, int'(ADDR_RSVD)));
		if (pick < 50)
			cmd = CMD_TICK;
		else if (pick < 70)
			cmd = CMD_READ;
		else if (pick < 97)
			cmd = CMD_WRITE;
		else
			cmd = CMD_NONE;
		if (cmd == CMD_WRITE) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				addr = ADDR_LOAD;
				// short loads so the counter keeps reaching zero
				if ($urandom_range(0, 3) != 0)
					data = $urandom_range(0, 24);
			end else if (pick < 65) begin
				addr = ADDR_CTRL;
				data[CTRL_EN_BIT] = ($urandom_range(0, 7) != 0);
				if ($urandom_range(0, 3) != 0)
					data[CTRL_PS_LSB +: 2] = PS_DIV1;
			end else if (pick < 75) begin
				addr = ADDR_CLEAR;
			end
		end
		if (cmd == CMD_TICK || cmd == CMD_NONE || $urandom_range(0, 15) == 0)
			addr = ADDR_WIDTH'($urandom_range(int'(ADDR_RSVD) + 1, ADDR_MAX));
		send_item(cmd, addr, data);
	endtask

	task automatic test_reset_state();
		send_item(CMD_READ, ADDR_LOAD, '0);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_item(CMD_READ, ADDR_CTRL, '0);
		send_item(CMD_READ, ADDR_CLEAR, '0);
		send_item(CMD_READ, ADDR_RSVD, '0);
		send_item(CMD_READ, ADDR_WIDTH'(int'(ADDR_RSVD) + 1), '1);
		send_item(CMD_READ, ADDR_WIDTH'(ADDR_MAX), '1);
		send_item(CMD_WRITE, ADDR_WIDTH'(ADDR_MAX), '1);
		send_item(CMD_WRITE, ADDR_VALUE, '1);
		send_item(CMD_WRITE, ADDR_RSVD, '1);
		send_item(CMD_NONE, ADDR_LOAD, '1);
		send_item(CMD_TICK, ADDR_LOAD, '0);
		send_item(CMD_READ, ADDR_VALUE, '0);
	endtask

	task automatic test_periodic_irq();
		// upper write bits must be dropped
		send_item(CMD_WRITE, ADDR_LOAD, '1);
		send_item(CMD_READ, ADDR_LOAD, '0);
		send_item(CMD_WRITE, ADDR_LOAD, 32'd2);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | CTRL_PERIODIC);
		send_item(CMD_READ, ADDR_CTRL, '0);
		send_ticks(2);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_item(CMD_WRITE, ADDR_CLEAR, '0);
		send_item(CMD_READ, ADDR_CLEAR, '0);
		// free running: reaching zero reloads all ones, no interrupt
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE);
		send_item(CMD_WRITE, ADDR_LOAD, 32'd1);
		send_ticks(1);
		send_item(CMD_READ, ADDR_VALUE, '0);
	endtask

	task automatic test_prescale();
		send_item(CMD_WRITE, ADDR_LOAD, 32'd100);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | (DATA_WIDTH'(PS_DIV16) << CTRL_PS_LSB));
		send_ticks(5);
		// prescaler count survives the divisor change
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | (DATA_WIDTH'(PS_DIV1) << CTRL_PS_LSB));
		send_ticks(1);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | (DATA_WIDTH'(PS_DIV16) << CTRL_PS_LSB));
		send_ticks(3);
		send_item(CMD_WRITE, ADDR_CTRL, DATA_WIDTH'(PS_DIV16) << CTRL_PS_LSB);
		send_ticks(5);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | (DATA_WIDTH'(PS_DIV16) << CTRL_PS_LSB));
		send_ticks(13);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_steady = 1'b1;
		send_item(CMD_WRITE, ADDR_CTRL,
			CTRL_ENABLE | CTRL_PERIODIC | (DATA_WIDTH'(PS_DIV256) << CTRL_PS_LSB));
		send_ticks(256);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_item(CMD_WRITE, ADDR_CTRL,
			CTRL_ENABLE | (DATA_WIDTH'(PS_DIV4096) << CTRL_PS_LSB));
		send_item(CMD_READ, ADDR_CTRL, '0);
		// partial divide-by-4096 run; the carried count then ends a divide-by-16 period
		send_ticks(300);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | (DATA_WIDTH'(PS_DIV16) << CTRL_PS_LSB));
		send_ticks(4);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_steady = 1'b0;
	endtask

	task automatic test_zero_reload();
		send_steady = 1'b1;
		recv_steady = 1'b1;
		send_item(CMD_WRITE, ADDR_CLEAR, '0);
		send_item(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | CTRL_PERIODIC);
		send_item(CMD_WRITE, ADDR_LOAD, '0);
		// a zero counter wraps to all ones on the next divided tick
		send_ticks(1);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_ticks(1);
		send_item(CMD_READ, ADDR_VALUE, '0);
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	task automatic test_random_traffic(int n);
		repeat (n) send_random_item();
	endtask

	task automatic test_steady_traffic(int n);
		send_steady = 1'b1;
		recv_steady = 1'b1;
		repeat (n) send_random_item();
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	task automatic test_output_backpressure(int n);
		send_steady     = 1'b1;
		rsp_hold_cycles = 150;
		repeat (n) send_random_item();
		send_steady = 1'b0;
	endtask

	// response side: random ready gaps, plus a long hold when requested
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end
			gap = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected response read_value %h status %b irq %b",
						$realtime, rsp_ch.read_value, rsp_ch.access_status,
						rsp_ch.irq_level);
			end else begin
				want = pending_rsp.pop_front();
				rsp_checked++;
				if (rsp_ch.read_value !== want.read_value ||
						rsp_ch.access_status !== want.access_status ||
						rsp_ch.irq_level !== want.irq_level) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display({"%0t: response %0d mismatch: expected read_value %h ",
							"status %b irq %b, got read_value %h status %b irq %b"},
							$realtime, rsp_checked, want.read_value,
							want.access_status, want.irq_level, rsp_ch.read_value,
							rsp_ch.access_status, rsp_ch.irq_level);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, pending_rsp.size());
			$display("prescaled_down_counter_timer_unit regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_TICK;
		req_ch.reg_addr    = '0;
		req_ch.write_value = '0;
		tmr_count          = '0;
		tmr_reload         = '0;
		tmr_enable         = 1'b0;
		tmr_periodic       = 1'b0;
		tmr_prescale       = PS_DIV1;
		tmr_ps_count       = '0;
		tmr_irq            = 1'b0;
		send_steady        = 1'b0;
		recv_steady        = 1'b0;
		rsp_hold_cycles    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_periodic_irq();
		test_prescale();
		test_zero_reload();
		test_random_traffic(600);
		test_steady_traffic(200);
		test_output_backpressure(100);
		test_random_traffic(100);

		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d transactions (ticks, register reads/writes, unmapped and idle",
			items_sent);
		$display("commands), %0d responses checked, %0d interrupt raises, %0d mismatches",
			rsp_checked, irq_raises, mismatches);
		if (mismatches == 0) begin
			$display("prescaled_down_counter_timer_unit regression: pass");
		end else begin
			$display("prescaled_down_counter_timer_unit regression: fail");
		end
		$finish;
	end

endmodule
